// ===== rtl/core/lmps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix plane scanner package
// Shared types, register codes, reset values and the column bit formatter.
// ----------------------------------------------------------------------------
package lmps_pkg;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   localparam logic [1:0] REG_DWELL_ZERO = 2'd0;
   localparam logic [1:0] REG_DWELL_ONE  = 2'd1;
   localparam logic [1:0] REG_DWELL_TWO  = 2'd2;

   localparam logic [8:0] DWELL_ZERO_RESET = 9'd12;
   localparam logic [8:0] DWELL_ONE_RESET  = 9'd20;
   localparam logic [8:0] DWELL_TWO_RESET  = 9'd50;
   localparam logic [8:0] COUNTDOWN_RESET  = 9'd21;

   localparam logic [7:0] ROW_MASK_RESET = 8'hFF;
   localparam logic [7:0] ROW_MASK_FIRST = 8'h7F;
   localparam logic [7:0] ROW_MASK_FILL  = 8'h80;

   typedef struct packed {
      op_type     op;
      logic [1:0] plane;
      logic [2:0] row;
      logic       sel;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic       en;
      logic [1:0] plane;
      logic [2:0] row;
      logic       sel;
      logic [7:0] data;
   } wr_req_type;

   // Shift order is byte 0 bits 5 to 7, byte 1 bits 0 and 1, then byte 0 bits 0 to 4.
   function automatic logic [9:0] col_bits(input logic [7:0] b0, input logic [7:0] b1);
      col_bits = ~{b0[4:0], b1[1:0], b0[7:5]};
   endfunction

endpackage

// ===== rtl/core/lmps_frame_store.sv =====
// ----------------------------------------------------------------------------
// LED matrix plane scanner frame store
// Two line bytes per row and plane, byte writes, one read port at the scan spot.
// ----------------------------------------------------------------------------
module lmps_frame_store #(
   parameter int ROWS   = 8,
   parameter int PLANES = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  lmps_pkg::wr_req_type wr,
   input  logic [1:0]         rd_plane,
   input  logic [2:0]         rd_row,
   output logic [7:0]         rd_byte0,
   output logic [7:0]         rd_byte1
);
   import lmps_pkg::*;

   localparam int DEPTH = ROWS * PLANES;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [15:0]      line_ff [DEPTH];
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_hit;
   logic [15:0]      rd_line;

   assign wr_hit = wr.en && (int'(wr.plane) < PLANES) && (int'(wr.row) < ROWS);
   assign wr_idx = IDX_W'(int'(wr.plane) * ROWS + int'(wr.row));
   assign rd_idx = IDX_W'(int'(rd_plane) * ROWS + int'(rd_row));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         if (wr.sel) begin
            line_ff[wr_idx][15:8] <= wr.data;
         end else begin
            line_ff[wr_idx][7:0] <= wr.data;
         end
      end
   end

   assign rd_line  = line_ff[rd_idx];
   assign rd_byte0 = rd_line[7:0];
   assign rd_byte1 = rd_line[15:8];

endmodule

// ===== rtl/core/led_matrix_plane_scanner.sv =====
// ----------------------------------------------------------------------------
// LED matrix plane scanner
// Frame store, dwell countdown and row/plane scan of a multiplexed LED matrix.
// ----------------------------------------------------------------------------
// The block takes one word per cycle, a frame store byte write or a timer tick,
// while no result stalls. Each word passes an input register, and a tick whose
// countdown expires presents its row drive mask and column bits in the result
// register; the frame store read and the countdown compare sit between those two
// registers. Any word, write or tick, holds in the input register while an earlier
// result still waits, so input stalls follow result stalls.
module led_matrix_plane_scanner #(
   parameter int ROWS   = 8,
   parameter int PLANES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [1:0]  req_wr_plane,
   input  logic [2:0]  req_wr_row,
   input  logic        req_wr_byte,
   input  logic [7:0]  req_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_row_drive,
   output logic [9:0]  rsp_col_bits,
   output logic [2:0]  rsp_shown_row,
   output logic [1:0]  rsp_shown_plane,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lmps_pkg::*;

   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_drive_ff, out_drive_in;
   logic [9:0] out_cols_ff, out_cols_in;
   logic [2:0] out_row_ff, out_row_in;
   logic [1:0] out_plane_ff, out_plane_in;
   logic [2:0] scan_row_ff, scan_row_in;
   logic [1:0] scan_plane_ff, scan_plane_in;
   logic [7:0] row_mask_ff, row_mask_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] dwell0_ff, dwell1_ff, dwell2_ff;
   logic [8:0] dwell_sel;
   logic       fire, expire, cfg_wr;
   logic [7:0] byte0, byte1;
   wr_req_type wr_req;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign expire    = fire && (item_ff.op == OP_TICK) && (count_ff <= 9'd1);

   assign wr_req.en    = fire && (item_ff.op == OP_WRITE);
   assign wr_req.plane = item_ff.plane;
   assign wr_req.row   = item_ff.row;
   assign wr_req.sel   = item_ff.sel;
   assign wr_req.data  = item_ff.data;

   lmps_frame_store #(
      .ROWS   (ROWS),
      .PLANES (PLANES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr_req),
      .rd_plane (scan_plane_ff),
      .rd_row   (scan_row_ff),
      .rd_byte0 (byte0),
      .rd_byte1 (byte1)
   );

   always_comb begin
      case (scan_plane_ff)
         REG_DWELL_ZERO: dwell_sel = dwell0_ff;
         REG_DWELL_ONE:  dwell_sel = dwell1_ff;
         default:        dwell_sel = dwell2_ff;
      endcase
   end

   always_comb begin
      item_in.op    = op_type'(req_op);
      item_in.plane = req_wr_plane;
      item_in.row   = req_wr_row;
      item_in.sel   = req_wr_byte;
      item_in.data  = req_wr_data;
      in_valid_in   = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

      count_in      = count_ff;
      row_mask_in   = row_mask_ff;
      scan_row_in   = scan_row_ff;
      scan_plane_in = scan_plane_ff;
      out_drive_in  = out_drive_ff;
      out_cols_in   = out_cols_ff;
      out_row_in    = out_row_ff;
      out_plane_in  = out_plane_ff;
      out_valid_in  = rsp_ready ? 1'b0 : out_valid_ff;

      if (fire && (item_ff.op == OP_TICK) && !expire) begin
         count_in = count_ff - 9'd1;
      end
      if (expire) begin
         row_mask_in = (scan_row_ff == 3'd0) ? ROW_MASK_FIRST
                                             : ((row_mask_ff >> 1) | ROW_MASK_FILL);
         count_in     = dwell_sel;
         out_valid_in = 1'b1;
         out_drive_in = row_mask_in;
         out_cols_in  = col_bits(byte0, byte1);
         out_row_in   = scan_row_ff;
         out_plane_in = scan_plane_ff;
         if (int'(scan_row_ff) >= ROWS - 1) begin
            scan_row_in   = 3'd0;
            scan_plane_in = (int'(scan_plane_ff) >= PLANES - 1) ? 2'd0
                                                               : scan_plane_ff + 2'd1;
         end else begin
            scan_row_in = scan_row_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         scan_row_ff   <= 3'd0;
         scan_plane_ff <= 2'd0;
         row_mask_ff   <= ROW_MASK_RESET;
         count_ff      <= COUNTDOWN_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         scan_row_ff   <= scan_row_in;
         scan_plane_ff <= scan_plane_in;
         row_mask_ff   <= row_mask_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      out_drive_ff <= out_drive_in;
      out_cols_ff  <= out_cols_in;
      out_row_ff   <= out_row_in;
      out_plane_ff <= out_plane_in;
   end

   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell0_ff <= DWELL_ZERO_RESET;
         dwell1_ff <= DWELL_ONE_RESET;
         dwell2_ff <= DWELL_TWO_RESET;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_DWELL_ZERO: dwell0_ff <= pwdata[8:0];
            REG_DWELL_ONE:  dwell1_ff <= pwdata[8:0];
            REG_DWELL_TWO:  dwell2_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_DWELL_ZERO: prdata = {23'd0, dwell0_ff};
         REG_DWELL_ONE:  prdata = {23'd0, dwell1_ff};
         REG_DWELL_TWO:  prdata = {23'd0, dwell2_ff};
         default:        prdata = 32'd0;
      endcase
   end

   assign pready          = 1'b1;
   assign rsp_valid       = out_valid_ff;
   assign rsp_row_drive   = out_drive_ff;
   assign rsp_col_bits    = out_cols_ff;
   assign rsp_shown_row   = out_row_ff;
   assign rsp_shown_plane = out_plane_ff;

endmodule

// ===== rtl/core/lmps_checker.sv =====
// ----------------------------------------------------------------------------
// LED matrix plane scanner checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lmps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_row_drive,
   input logic [9:0] rsp_col_bits,
   input logic [2:0] rsp_shown_row,
   input logic [1:0] rsp_shown_plane
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_drive)
         && $stable(rsp_col_bits) && $stable(rsp_shown_row) && $stable(rsp_shown_plane))
      else $error("stalled result word changed");

   a_row_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_drive[3'd7 - rsp_shown_row] == 1'b0)
      else $error("shown row is not driven low");

   a_first_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_row == 3'd0 |-> rsp_row_drive == 8'h7F)
      else $error("first row mask is wrong");

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_plane != 2'd3)
      else $error("shown plane out of range");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind led_matrix_plane_scanner lmps_checker u_lmps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_row_drive   (rsp_row_drive),
   .rsp_col_bits    (rsp_col_bits),
   .rsp_shown_row   (rsp_shown_row),
   .rsp_shown_plane (rsp_shown_plane)
);

// ===== test/lmps_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix plane scanner checker
// Watches the word, result and register ports, keeps its own copy of the
// frame store, dwell registers and scan position, and compares every result
// word against the oldest predicted lit row.
// ----------------------------------------------------------------------------
module lmps_scan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [1:0]  req_wr_plane,
   input  logic [2:0]  req_wr_row,
   input  logic        req_wr_byte,
   input  logic [7:0]  req_wr_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_row_drive,
   input  logic [9:0]  rsp_col_bits,
   input  logic [2:0]  rsp_shown_row,
   input  logic [1:0]  rsp_shown_plane,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending
);
   import lmps_pkg::*;

   localparam int ROWS   = 8;
   localparam int PLANES = 3;

   typedef struct packed {
      logic [7:0] row_drive;
      logic [9:0] col_bits;
      logic [2:0] row;
      logic [1:0] plane;
   } lit_row_type;

   logic [7:0]  frame [PLANES][ROWS][2];
   logic [8:0]  dwell [3];
   logic [2:0]  scan_row;
   logic [1:0]  scan_plane;
   logic [7:0]  row_mask;
   logic [8:0]  countdown;
   lit_row_type rows_due [$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors = errors + 1;
      if (errors <= 20) begin
         $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   function automatic bit scan_word(input logic op, input logic [1:0] plane,
                                    input logic [2:0] row, input logic sel,
                                    input logic [7:0] data, output lit_row_type lit);
      logic [7:0] b0;
      logic [7:0] b1;
      int k;
      lit = '0;
      if (op == OP_WRITE) begin
         if (plane < PLANES && row < ROWS) begin
            frame[plane][row][sel] = data;
         end
         return 1'b0;
      end
      if (countdown > 9'd1) begin
         countdown = countdown - 9'd1;
         return 1'b0;
      end
      row_mask  = (scan_row == 3'd0) ? ROW_MASK_FIRST : ((row_mask >> 1) | ROW_MASK_FILL);
      countdown = dwell[scan_plane];
      b0 = frame[scan_plane][scan_row][0];
      b1 = frame[scan_plane][scan_row][1];
      for (k = 0; k < 3; k++) lit.col_bits[k] = ~b0[5 + k];
      for (k = 0; k < 2; k++) lit.col_bits[3 + k] = ~b1[k];
      for (k = 0; k < 5; k++) lit.col_bits[5 + k] = ~b0[k];
      lit.row_drive = row_mask;
      lit.row       = scan_row;
      lit.plane     = scan_plane;
      if (scan_row == 3'(ROWS - 1)) begin
         scan_row   = 3'd0;
         scan_plane = (scan_plane == 2'(PLANES - 1)) ? 2'd0 : scan_plane + 2'd1;
      end else begin
         scan_row = scan_row + 3'd1;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      lit_row_type want;
      lit_row_type lit;
      if (reset) begin
         for (int p = 0; p < PLANES; p++) begin
            for (int r = 0; r < ROWS; r++) begin
               frame[p][r][0] = 8'h00;
               frame[p][r][1] = 8'h00;
            end
         end
         dwell[0]   = DWELL_ZERO_RESET;
         dwell[1]   = DWELL_ONE_RESET;
         dwell[2]   = DWELL_TWO_RESET;
         scan_row   = 3'd0;
         scan_plane = 2'd0;
         row_mask   = ROW_MASK_RESET;
         countdown  = COUNTDOWN_RESET;
         rows_due.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rows_due.size() == 0) begin
               report_mismatch("result word with none expected", rsp_row_drive, 0);
            end else begin
               want = rows_due.pop_front();
               if (rsp_row_drive !== want.row_drive) begin
                  report_mismatch("row_drive", rsp_row_drive, want.row_drive);
               end
               if (rsp_col_bits !== want.col_bits) begin
                  report_mismatch("col_bits", rsp_col_bits, want.col_bits);
               end
               if (rsp_shown_row !== want.row) begin
                  report_mismatch("shown_row", rsp_shown_row, want.row);
               end
               if (rsp_shown_plane !== want.plane) begin
                  report_mismatch("shown_plane", rsp_shown_plane, want.plane);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (scan_word(req_op, req_wr_plane, req_wr_row, req_wr_byte, req_wr_data, lit)) begin
               rows_due.push_back(lit);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_DWELL_ZERO: dwell[0] = pwdata[8:0];
               REG_DWELL_ONE:  dwell[1] = pwdata[8:0];
               REG_DWELL_TWO:  dwell[2] = pwdata[8:0];
               default: ;
            endcase
         end
         pending <= rows_due.size();
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix plane scanner testbench
// Drives frame store writes and timer ticks in random bursts, reprograms the
// plane dwell registers between phases, stalls the result side and lets the
// checker judge every lit row.
// ----------------------------------------------------------------------------
module tb;
   import lmps_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [1:0]  req_wr_plane;
   logic [2:0]  req_wr_row;
   logic        req_wr_byte;
   logic [7:0]  req_wr_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_row_drive;
   logic [9:0]  rsp_col_bits;
   logic [2:0]  rsp_shown_row;
   logic [1:0]  rsp_shown_plane;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          errors;
   int          pending;

   led_matrix_plane_scanner u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_wr_plane    (req_wr_plane),
      .req_wr_row      (req_wr_row),
      .req_wr_byte     (req_wr_byte),
      .req_wr_data     (req_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_drive   (rsp_row_drive),
      .rsp_col_bits    (rsp_col_bits),
      .rsp_shown_row   (rsp_shown_row),
      .rsp_shown_plane (rsp_shown_plane),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   lmps_scan_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_wr_plane    (req_wr_plane),
      .req_wr_row      (req_wr_row),
      .req_wr_byte     (req_wr_byte),
      .req_wr_data     (req_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_drive   (rsp_row_drive),
      .rsp_col_bits    (rsp_col_bits),
      .rsp_shown_row   (rsp_shown_row),
      .rsp_shown_plane (rsp_shown_plane),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .errors          (errors),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // The result side switches between always ready, coin-flip ready and long stalls.
   initial begin
      int stall_mode;
      int span;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall_mode = $urandom_range(0, 2);
         span       = $urandom_range(64, 256);
         repeat (span) begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input op_type op, input logic [1:0] plane, input logic [2:0] row,
                            input logic sel, input logic [7:0] data);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_wr_plane <= plane;
      req_wr_row   <= row;
      req_wr_byte  <= sel;
      req_wr_data  <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_dwell(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int         done;
      int         burst;
      int         i;
      logic [1:0] plane;
      logic [7:0] data;
      done = 0;
      while (done < count) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
         i = 0;
         while (i < burst && done < count) begin
            if ($urandom_range(0, 9) < 3) begin
               plane = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
               case ($urandom_range(0, 7))
                  0:       data = 8'h00;
                  1:       data = 8'hFF;
                  default: data = 8'($urandom);
               endcase
               send_word(OP_WRITE, plane, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), data);
               if (plane != 2'd3) done++;
            end else begin
               send_word(OP_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 8'($urandom));
               done++;
            end
            i++;
         end
         if (done < count) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [8:0] d0;
      logic [8:0] d1;
      logic [8:0] d2;
      int         phase;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_op       <= OP_WRITE;
      req_wr_plane <= 2'd0;
      req_wr_row   <= 3'd0;
      req_wr_byte  <= 1'b0;
      req_wr_data  <= 8'h00;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= 4'd0;
      pwdata       <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Upper bits of the value are dropped, so plane zero gets a dwell of zero.
      write_dwell(REG_DWELL_ZERO, 32'hFFFF_FE00);
      write_dwell(REG_UNUSED, 32'h0000_0001);
      send_word(OP_WRITE, 2'd0, 3'd0, 1'b0, 8'hFF);
      send_word(OP_WRITE, 2'd0, 3'd0, 1'b1, 8'hFE);
      send_word(OP_WRITE, 2'd0, 3'd1, 1'b1, 8'hFF);
      send_word(OP_WRITE, 2'd3, 3'd1, 1'b0, 8'hFF);
      send_word(OP_WRITE, 2'd2, 3'd7, 1'b1, 8'hFF);
      repeat (23) send_word(OP_TICK, 2'd3, 3'd7, 1'b1, 8'hFF);

      for (phase = 0; phase < 10; phase++) begin
         settle();
         case (phase)
            0: begin d0 = 9'd1;   d1 = 9'd1;   d2 = 9'd1;   end
            1: begin d0 = 9'd2;   d1 = 9'd3;   d2 = 9'd4;   end
            2: begin d0 = 9'd511; d1 = 9'd1;   d2 = 9'd1;   end
            3: begin d0 = 9'd256; d1 = 9'd256; d2 = 9'd256; end
            4: begin d0 = 9'd1;   d1 = 9'd256; d2 = 9'd2;   end
            5: begin d0 = 9'd12;  d1 = 9'd20;  d2 = 9'd50;  end
            default: begin
               d0 = 9'($urandom_range(0, 6));
               d1 = 9'($urandom_range(0, 6));
               d2 = 9'($urandom_range(0, 6));
            end
         endcase
         write_dwell(REG_DWELL_ZERO, ($urandom & 32'hFFFF_FE00) | d0);
         write_dwell(REG_DWELL_ONE,  ($urandom & 32'hFFFF_FE00) | d1);
         write_dwell(REG_DWELL_TWO,  ($urandom & 32'hFFFF_FE00) | d2);
         if (phase == 7) write_dwell(REG_UNUSED, $urandom);
         run_random(190);
      end
      settle();

      if (errors == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
